@@ hdl/mcds_pkg.sv @@
// ----------------------------------------------------------------------------
// mcds_pkg
// Shared types, constants and graph functions for the minimal connected
// dominating set checker on the trapezohedron graph.
// ----------------------------------------------------------------------------
package mcds_pkg;

    // graph size limits
    localparam int MIN_RIM  = 3;
    localparam int MAX_RIM  = 14;
    localparam int NUM_VERT = 2 * MAX_RIM + 2;
    localparam int VIDX_W   = $clog2(NUM_VERT);

    // field widths
    localparam int RIM_W   = 4;
    localparam int SIZE_W  = 5;
    localparam int EDGE_W  = 6;
    localparam int TWICE_W = EDGE_W + 1;

    typedef logic [NUM_VERT-1:0] t_vmask;
    typedef logic [VIDX_W-1:0]   t_vidx;
    typedef logic [RIM_W-1:0]    t_rim;
    typedef logic [SIZE_W-1:0]   t_size;
    typedef logic [EDGE_W-1:0]   t_edges;
    typedef logic [TWICE_W-1:0]  t_twice;

    // fixed vertex numbers
    localparam t_vidx V_NORTH     = t_vidx'(0);
    localparam t_vidx V_SOUTH     = t_vidx'(1);
    localparam t_vidx V_FIRST_RIM = t_vidx'(2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;
    } t_dp_status;

    // saturate the rim count into its legal range
    function automatic t_rim f_clamp_rim(input t_rim r);
        t_rim c;
        c = r;
        if (r < t_rim'(MIN_RIM)) c = t_rim'(MIN_RIM);
        if (r > t_rim'(MAX_RIM)) c = t_rim'(MAX_RIM);
        return c;
    endfunction

    // number of vertices, 2n+2
    function automatic t_vidx f_order(input t_rim n);
        return t_vidx'({n, 1'b0}) + t_vidx'(2);
    endfunction

    // mask of vertices below the vertex count
    function automatic t_vmask f_valid_mask(input t_rim n);
        t_vmask m;
        t_vidx  ord;
        ord = f_order(n);
        for (int k = 0; k < NUM_VERT; k++) begin
            m[k] = (t_vidx'(k) < ord);
        end
        return m;
    endfunction

    // open neighborhood of one vertex
    function automatic t_vmask f_adj(input t_vidx v, input t_rim n);
        t_vmask m;
        t_vidx  ord;
        t_vidx  last_b;
        m      = '0;
        ord    = f_order(n);
        last_b = ord - t_vidx'(1);
        if (v < ord) begin
            if (v == V_NORTH) begin
                for (int k = 0; k < MAX_RIM; k++) begin
                    if (k < int'(n)) m[2 + 2 * k] = 1'b1;
                end
            end else if (v == V_SOUTH) begin
                for (int k = 0; k < MAX_RIM; k++) begin
                    if (k < int'(n)) m[3 + 2 * k] = 1'b1;
                end
            end else if (!v[0]) begin
                // a(i): north pole, b(i), b(i-1) wrapping to the last b
                m[V_NORTH]          = 1'b1;
                m[v + t_vidx'(1)]   = 1'b1;
                if (v == V_FIRST_RIM) begin
                    m[last_b] = 1'b1;
                end else begin
                    m[v - t_vidx'(1)] = 1'b1;
                end
            end else begin
                // b(i): south pole, a(i), a(i+1) wrapping to the first a
                m[V_SOUTH]          = 1'b1;
                m[v - t_vidx'(1)]   = 1'b1;
                if (v == last_b) begin
                    m[V_FIRST_RIM] = 1'b1;
                end else begin
                    m[v + t_vidx'(1)] = 1'b1;
                end
            end
        end
        return m;
    endfunction

    // union of the neighborhoods of a vertex set
    function automatic t_vmask f_nbr(input t_vmask s, input t_rim n);
        t_vmask m;
        m = '0;
        for (int u = 0; u < NUM_VERT; u++) begin
            if (s[u]) m = m | f_adj(t_vidx'(u), n);
        end
        return m;
    endfunction

    // population count of a vertex mask
    function automatic t_size f_popcount(input t_vmask s);
        t_size c;
        c = '0;
        for (int k = 0; k < NUM_VERT; k++) begin
            c = c + t_size'(s[k]);
        end
        return c;
    endfunction

endpackage

@@ hdl/mcds_cfg_if.sv @@
// ----------------------------------------------------------------------------
// mcds_cfg_if
// Configuration write channel carrying the rim count.
// ----------------------------------------------------------------------------
interface mcds_cfg_if import mcds_pkg::*;;
    logic valid;
    logic ready;
    t_rim rim_count;

    modport source (output valid, output rim_count, input ready);
    modport sink   (input valid, input rim_count, output ready);
endinterface

@@ hdl/mcds_in_if.sv @@
// ----------------------------------------------------------------------------
// mcds_in_if
// Input channel carrying one candidate vertex subset per beat.
// ----------------------------------------------------------------------------
interface mcds_in_if import mcds_pkg::*;;
    logic   valid;
    logic   ready;
    t_vmask subset;

    modport source (output valid, output subset, input ready);
    modport sink   (input valid, input subset, output ready);
endinterface

@@ hdl/mcds_out_if.sv @@
// ----------------------------------------------------------------------------
// mcds_out_if
// Result channel carrying the verdict and counts for one subset per beat.
// ----------------------------------------------------------------------------
interface mcds_out_if import mcds_pkg::*;;
    logic   valid;
    logic   ready;
    logic   accepted;
    logic   out_of_range;
    t_size  set_size;
    t_edges induced_edges;

    modport source (output valid, output accepted, output out_of_range,
                    output set_size, output induced_edges, input ready);
    modport sink   (input valid, input accepted, input out_of_range,
                    input set_size, input induced_edges, output ready);
endinterface

@@ hdl/mcds_ctrl.sv @@
// ----------------------------------------------------------------------------
// mcds_ctrl
// Controller: sequences load, vertex sweep and result hand-off, and owns
// the valid flag of the result register.
// ----------------------------------------------------------------------------
module mcds_ctrl import mcds_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SWEEP;
            end
            S_SWEEP: begin
                if (i_status.last) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SWEEP: begin
                o_cmd.step = 1'b1;
            end
            S_FINISH: begin
                o_cmd.finish = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // result valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_load_finish_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load && o_cmd.finish))
        else $error("load and finish in the same cycle");

    a_finish_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_out_valid)
        else $error("finished result not presented");

    a_sweep_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && i_status.last) |=> (r_state == S_FINISH))
        else $error("sweep did not end on last vertex");
`endif

endmodule

@@ hdl/mcds_dp.sv @@
// ----------------------------------------------------------------------------
// mcds_dp
// Datapath: holds the subset, sweeps one vertex per cycle for domination,
// private neighbors and edge count, grows the connected closure one hop per
// cycle, and holds the result register and the rim count register.
// ----------------------------------------------------------------------------
module mcds_dp import mcds_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  t_rim       i_cfg_rim,
    input  t_vmask     i_subset,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_accepted,
    output logic       o_out_of_range,
    output t_size      o_set_size,
    output t_edges     o_induced_edges
);

    t_rim   r_rim;
    t_rim   rim_n;
    t_vidx  order;
    t_vmask valid_mask;

    t_vmask r_subset;
    t_vidx  r_vtx;
    logic   r_dom;
    t_vmask r_priv;
    t_vmask r_seen;
    t_twice r_twice;
    t_size  r_size;
    logic   r_oor;

    logic   r_accepted;
    logic   r_res_oor;
    t_size  r_res_size;
    t_edges r_res_edges;

    t_vmask adj_v;
    t_vmask hit;
    logic   hit_single;
    t_size  deg_in;

    assign rim_n      = f_clamp_rim(r_rim);
    assign order      = f_order(rim_n);
    assign valid_mask = f_valid_mask(rim_n);

    // rim count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rim <= t_rim'(MIN_RIM);
        end else if (i_cfg_we) begin
            r_rim <= i_cfg_rim;
        end
    end

    // closed neighborhood of the current vertex within the subset
    always_comb begin
        adj_v      = f_adj(r_vtx, rim_n);
        hit        = (adj_v | (t_vmask'(1) << r_vtx)) & r_subset;
        hit_single = (hit != '0) && ((hit & (hit - t_vmask'(1))) == '0);
        deg_in     = f_popcount(adj_v & r_subset);
    end

    assign o_status.last = (r_vtx == order - t_vidx'(1));

    // sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtx <= '0;
        end else if (i_cmd.load) begin
            r_vtx <= '0;
        end else if (i_cmd.step) begin
            r_vtx <= r_vtx + t_vidx'(1);
        end
    end

    // per-item working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_subset <= i_subset;
            r_dom    <= 1'b1;
            r_priv   <= '0;
            r_seen   <= i_subset & (~i_subset + t_vmask'(1));
            r_twice  <= '0;
            r_size   <= f_popcount(i_subset);
            r_oor    <= (i_subset & ~valid_mask) != '0;
        end else if (i_cmd.step) begin
            if (hit == '0) r_dom <= 1'b0;
            if (hit_single) r_priv <= r_priv | hit;
            if (r_subset[r_vtx]) r_twice <= r_twice + t_twice'(deg_in);
            // one hop of the connected closure
            r_seen <= r_seen | (f_nbr(r_seen, rim_n) & r_subset);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_accepted  <= !r_oor && r_dom && (r_priv == r_subset) &&
                           (r_seen == r_subset);
            r_res_oor   <= r_oor;
            r_res_size  <= r_size;
            r_res_edges <= r_twice[TWICE_W-1:1];
        end
    end

    assign o_accepted      = r_accepted;
    assign o_out_of_range  = r_res_oor;
    assign o_set_size      = r_res_size;
    assign o_induced_edges = r_res_edges;

`ifndef SYNTHESIS
    a_oor_rejects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_oor) |=> !r_accepted)
        else $error("out of range subset accepted");

    a_vtx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_vtx < order))
        else $error("sweep past vertex count");
`endif

endmodule

@@ hdl/minimal_connected_dominating_set_check.sv @@
// ----------------------------------------------------------------------------
// minimal_connected_dominating_set_check
// Tests each candidate subset of the trapezohedron graph for being a
// minimal dominating set with a connected induced subgraph.
//
// channel   dir  payload                                         beat when
// i_cfg     in   rim_count                                       valid & ready
// i_in      in   subset                                          valid & ready
// o_out     out  accepted, out_of_range, set_size, induced_edges valid & ready
//
// From accept to the next accept, an item goes through a load, then the vertex
// sweep, one vertex per cycle over all 2n+2 vertices, then a finish. Reset is
// synchronous, active low; rim count resets to 3.
// A result that is not taken holds in the result register; the next subset is
// accepted meanwhile, and only its finish waits for the register to free up.
// ----------------------------------------------------------------------------
module minimal_connected_dominating_set_check import mcds_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mcds_cfg_if.sink      i_cfg,
    mcds_in_if.sink       i_in,
    mcds_out_if.source    o_out
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // configuration is always taken
    assign i_cfg.ready = 1'b1;

    // sequencing
    mcds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // checking datapath
    mcds_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_rim       (i_cfg.rim_count),
        .i_subset        (i_in.subset),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_accepted      (o_out.accepted),
        .o_out_of_range  (o_out.out_of_range),
        .o_set_size      (o_out.set_size),
        .o_induced_edges (o_out.induced_edges)
    );

endmodule

@@ dv/tb_minimal_connected_dominating_set_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_minimal_connected_dominating_set_check
// Self-checking bench for the trapezohedron dominating set checker. Each
// accepted subset goes into a scoreboard, which predicts the verdict with its
// own copy of the graph. Results are then compared field by field in order.
// The bench drives directed corner subsets first. It then runs randomized
// phases at several rim counts. Most of their subsets are built as minimal
// dominating sets, with some noise and some damaged sets. Both sides idle at
// random, and one phase holds off the result side for a long stretch.
// ----------------------------------------------------------------------------
module tb_minimal_connected_dominating_set_check;
    import mcds_pkg::*;

    typedef struct packed {
        logic   accepted;
        logic   out_of_range;
        t_size  set_size;
        t_edges induced_edges;
    } t_verdict;

    // graph model, verdict predictor and queue of verdicts still to arrive
    class subset_verdict_board;
        t_vmask   adj [NUM_VERT];
        t_vmask   valid;
        int       order;
        t_verdict verdicts_due [$];
        int       errors;

        function new();
            errors = 0;
            load_rim(t_rim'(MIN_RIM));
        endfunction

        // rebuild the graph for a written rim count, saturated into range
        function void load_rim(t_rim raw);
            int n;
            int ai;
            int bi;
            int an;
            n = int'(raw);
            if (n < MIN_RIM) n = MIN_RIM;
            if (n > MAX_RIM) n = MAX_RIM;
            order = 2 * n + 2;
            valid = '0;
            for (int k = 0; k < NUM_VERT; k++) begin
                adj[k] = '0;
                if (k < order) valid[k] = 1'b1;
            end
            for (int i = 0; i < n; i++) begin
                ai = 2 + 2 * i;
                bi = 3 + 2 * i;
                an = 2 + 2 * ((i + 1) % n);
                adj[0][ai] = 1'b1;  adj[ai][0] = 1'b1;
                adj[1][bi] = 1'b1;  adj[bi][1] = 1'b1;
                adj[ai][bi] = 1'b1; adj[bi][ai] = 1'b1;
                adj[bi][an] = 1'b1; adj[an][bi] = 1'b1;
            end
        endfunction

        function t_vmask closed_nbr(int v);
            t_vmask m;
            m = adj[v];
            m[v] = 1'b1;
            return m;
        endfunction

        function bit dominates(t_vmask d);
            for (int v = 0; v < order; v++) begin
                if ((closed_nbr(v) & d) == '0) return 1'b0;
            end
            return 1'b1;
        endfunction

        // every member owns a vertex that no other member covers
        function bit all_private(t_vmask d);
            t_vmask priv;
            t_vmask hit;
            priv = '0;
            for (int v = 0; v < order; v++) begin
                hit = closed_nbr(v) & d;
                if (hit != '0 && (hit & (hit - t_vmask'(1))) == '0) priv = priv | hit;
            end
            return priv == d;
        endfunction

        // grow from the lowest member until nothing new is reached
        function bit connected(t_vmask d);
            t_vmask seen;
            t_vmask prev;
            seen = d & (~d + t_vmask'(1));
            do begin
                prev = seen;
                for (int v = 0; v < NUM_VERT; v++) begin
                    if (seen[v]) seen = seen | (adj[v] & d);
                end
            end while (seen != prev);
            return seen == d;
        endfunction

        function t_verdict predict_verdict(t_vmask d);
            t_verdict r;
            int       twice;
            twice = 0;
            for (int v = 0; v < NUM_VERT; v++) begin
                if (d[v] && valid[v]) twice += $countones(adj[v] & d);
            end
            r.out_of_range  = (d & ~valid) != '0;
            r.accepted      = !r.out_of_range && dominates(d) && all_private(d)
                              && connected(d);
            r.set_size      = t_size'($countones(d));
            r.induced_edges = t_edges'(twice / 2);
            return r;
        endfunction

        // drop vertices in random order while the set still dominates and, when asked, stays connected
        function t_vmask shrink_cover(bit keep_connected);
            int     perm [NUM_VERT];
            int     j;
            int     tmp;
            t_vmask s;
            t_vmask t;
            for (int k = 0; k < NUM_VERT; k++) perm[k] = k;
            for (int k = order - 1; k > 0; k--) begin
                j = $urandom_range(0, k);
                tmp = perm[k];
                perm[k] = perm[j];
                perm[j] = tmp;
            end
            s = valid;
            for (int k = 0; k < order; k++) begin
                t = s;
                t[perm[k]] = 1'b0;
                if (t != '0 && dominates(t) && (!keep_connected || connected(t))) s = t;
            end
            return s;
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        function void note_subset(t_vmask d);
            verdicts_due.push_back(predict_verdict(d));
        endfunction

        task flag_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_verdict(t_verdict got);
            t_verdict want;
            if (verdicts_due.size() == 0) begin
                flag_mismatch("result beat with no subset outstanding");
                return;
            end
            want = verdicts_due.pop_front();
            if (got.accepted !== want.accepted)
                flag_mismatch($sformatf("accepted got %0b want %0b",
                                        got.accepted, want.accepted));
            if (got.out_of_range !== want.out_of_range)
                flag_mismatch($sformatf("out_of_range got %0b want %0b",
                                        got.out_of_range, want.out_of_range));
            if (got.set_size !== want.set_size)
                flag_mismatch($sformatf("set_size got %0d want %0d",
                                        got.set_size, want.set_size));
            if (got.induced_edges !== want.induced_edges)
                flag_mismatch($sformatf("induced_edges got %0d want %0d",
                                        got.induced_edges, want.induced_edges));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    mcds_cfg_if cfg_if ();
    mcds_in_if  in_if ();
    mcds_out_if out_if ();

    minimal_connected_dominating_set_check dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    subset_verdict_board board;
    t_verdict            seen_beat;
    bit                  no_idle;
    int                  hold_off_len;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    initial begin
        #4_000_000;
        $display("minimal_connected_dominating_set_check regression: fail");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // random subset: mostly built covers, some damaged, some noise
    function automatic t_vmask pick_subset();
        int     r;
        t_vmask s;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            s = board.shrink_cover(1'b1);
        end else if (r < 55) begin
            s = board.shrink_cover(1'b0);
        end else if (r < 70) begin
            s = board.shrink_cover($urandom_range(0, 1));
            s[$urandom_range(0, board.order - 1)] ^= 1'b1;
        end else if (r < 80) begin
            s = t_vmask'($urandom()) & board.valid;
        end else if (r < 90) begin
            s = t_vmask'($urandom());
        end else begin
            s = board.shrink_cover(1'b1);
            s[$urandom_range(board.order, NUM_VERT - 1)] = 1'b1;
        end
        return s;
    endfunction

    // one subset beat, then a random gap
    task automatic send_subset(input t_vmask s);
        int gap;
        in_if.valid  <= 1'b1;
        in_if.subset <= s;
        do @(posedge i_clk); while (!in_if.ready);
        board.note_subset(s);
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // wait until the block has drained, then write the rim count
    task automatic write_rim(input t_rim value);
        in_if.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.rim_count <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        board.load_rim(value);
    endtask

    // result side ready, with random stalls and a requested hold-off
    initial begin
        int len;
        int gap;
        out_if.ready = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_off_len != 0) begin
                len = hold_off_len;
                hold_off_len = 0;
                out_if.ready <= 1'b0;
                repeat (len) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
                gap = pick_gap();
                if (gap > 0) begin
                    out_if.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    // result beat check
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            seen_beat.accepted      = out_if.accepted;
            seen_beat.out_of_range  = out_if.out_of_range;
            seen_beat.set_size      = out_if.set_size;
            seen_beat.induced_edges = out_if.induced_edges;
            board.check_verdict(seen_beat);
        end
    end

    // stimulus
    initial begin
        t_rim phase_rim [10];
        board            = new();
        no_idle          = 1'b0;
        hold_off_len     = 0;
        i_rst_n          = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.rim_count = '0;
        in_if.valid      = 1'b0;
        in_if.subset     = '0;
        phase_rim = '{t_rim'(14), t_rim'(5), t_rim'(1), t_rim'(15), t_rim'(9),
                      t_rim'(3), t_rim'(12), t_rim'(2), t_rim'(7), t_rim'(14)};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corner subsets at the reset rim count
        send_subset(30'h0000_0000);
        send_subset(30'h3FFF_FFFF);
        send_subset(30'h0000_00FF);
        send_subset(30'h0000_0080);
        send_subset(30'h0000_0100);
        send_subset(30'h2000_0000);
        send_subset(30'h0000_0003);
        send_subset(30'h0000_0055);
        send_subset(30'h0000_000F);
        repeat (4) send_subset(board.shrink_cover(1'b1));
        repeat (2) send_subset(board.shrink_cover(1'b0));
        send_subset(board.shrink_cover(1'b1) | 30'h0000_0100);

        // rim count below range saturates to the minimum
        write_rim(t_rim'(0));
        send_subset(30'h0000_00FF);
        send_subset(30'h0000_0100);
        send_subset(board.shrink_cover(1'b1));

        // rim count above range saturates to the maximum
        write_rim(t_rim'(15));
        send_subset(30'h3FFF_FFFF);
        send_subset(30'h1555_5555);
        repeat (2) send_subset(board.shrink_cover(1'b1));

        // randomized phases
        foreach (phase_rim[p]) begin
            write_rim(phase_rim[p]);
            no_idle = (p == 4) || (p == 6);
            if (p == 4) hold_off_len = 400;
            repeat (43) send_subset(pick_subset());
        end
        no_idle = 1'b0;

        // drain
        in_if.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("minimal_connected_dominating_set_check regression: pass");
        end else begin
            $display("minimal_connected_dominating_set_check regression: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/mcds_pkg.sv
hdl/mcds_cfg_if.sv
hdl/mcds_in_if.sv
hdl/mcds_out_if.sv
hdl/mcds_ctrl.sv
hdl/mcds_dp.sv
hdl/minimal_connected_dominating_set_check.sv
dv/tb_minimal_connected_dominating_set_check.sv
